@@ hdl/gde_pkg.sv @@
// Shared types, codes and helpers for the group debounce edge detector.
// No dependencies; imported by gde_sweep and group_debounce_edge_detector_core.
`default_nettype none

package gde_pkg;

	// Pin count of the group; only pins below both NUM_PINS and PIN_W are swept.
	localparam int NUM_PINS   = 8;
	localparam int PIN_W      = 8;
	localparam int NPIN_EFF   = (NUM_PINS > PIN_W) ? PIN_W : NUM_PINS;
	localparam int ST_W       = 3;
	localparam int STATUS_W   = PIN_W * ST_W;
	localparam int TICK_W     = 32;
	localparam int PHASE_W    = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_TDATA_W  = 40;  // pin_levels, now_tick
	localparam int OUT_TDATA_W = 32;  // pin_status, phase, zero fill

	typedef enum logic [PHASE_W-1:0] {
		PH_CHECK  = 2'd0,
		PH_WAIT   = 2'd1,
		PH_UPDATE = 2'd2
	} phase_t;

	typedef enum logic [ST_W-1:0] {
		ST_LOW     = 3'd0,
		ST_HIGH    = 3'd1,
		ST_FALL    = 3'd2,
		ST_RISE    = 3'd3,
		ST_UNKNOWN = 3'd4
	} pin_st_t;

	typedef enum logic {
		REG_DEBOUNCE_TICKS = 1'b0,
		REG_PIN_ENABLE     = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ACT_SWEEP      = 1'b0,
		ACT_REBASELINE = 1'b1
	} action_t;

	typedef struct packed {
		logic [PIN_W-1:0]            last_levels;
		logic [PIN_W-1:0][ST_W-1:0]  node_status;
		phase_t                      phase;
		logic [TICK_W-1:0]           start_tick;
	} gde_state_t;

	// Bits of the status word that belong to enabled, handled pins.
	function automatic logic [STATUS_W-1:0] status_mask(input logic [PIN_W-1:0] enable);
		logic [STATUS_W-1:0] m;
		m = '0;
		for (int i = 0; i < NPIN_EFF; i++) begin
			if (enable[i]) begin
				m[i*ST_W +: ST_W] = {ST_W{1'b1}};
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

@@ hdl/gde_sweep.sv @@
// One sweep of the debounce state machine: next state and result for one word.
// Depends on gde_pkg. Purely combinational; registers live in the top level.
`default_nettype none

module gde_sweep (
	input  wire logic                              action,
	input  wire logic [gde_pkg::PIN_W-1:0]         pin_levels,
	input  wire logic [gde_pkg::TICK_W-1:0]        now_tick,
	input  wire logic [gde_pkg::TICK_W-1:0]        debounce_ticks,
	input  wire logic [gde_pkg::PIN_W-1:0]         pin_enable,
	input  gde_pkg::gde_state_t                    cur,
	output gde_pkg::gde_state_t                    nxt,
	output logic [gde_pkg::STATUS_W-1:0]           pin_status,
	output gde_pkg::phase_t                        phase
);
	import gde_pkg::*;

	logic [TICK_W-1:0] elapsed;
	logic              timeout;
	logic              changed;

	assign elapsed = now_tick - cur.start_tick;
	assign timeout = (elapsed >= debounce_ticks);

	// Next state
	always_comb begin
		nxt     = cur;
		changed = 1'b0;
		if (action == ACT_REBASELINE) begin
			nxt.last_levels = pin_levels;
			nxt.start_tick  = now_tick;
			nxt.phase       = PH_CHECK;
		end else begin
			unique case (cur.phase)
				PH_WAIT: begin
					if (timeout) begin
						nxt.phase = PH_UPDATE;
					end
				end
				PH_UPDATE: begin
					for (int i = 0; i < NPIN_EFF; i++) begin
						if (pin_enable[i]) begin
							if (pin_levels[i] != cur.last_levels[i]) begin
								nxt.node_status[i] = pin_levels[i] ? ST_RISE : ST_FALL;
							end
							nxt.last_levels[i] = pin_levels[i];
						end
					end
					nxt.phase      = PH_CHECK;
					nxt.start_tick = now_tick;
				end
				default: begin
					for (int i = 0; i < NPIN_EFF; i++) begin
						if (pin_enable[i]) begin
							if (pin_levels[i] != cur.last_levels[i]) begin
								nxt.node_status[i] = ST_UNKNOWN;
								changed = 1'b1;
							end else begin
								nxt.node_status[i] = pin_levels[i] ? ST_HIGH : ST_LOW;
							end
						end
					end
					if (changed) begin
						nxt.phase = PH_WAIT;
					end
				end
			endcase
		end
	end

	// Outputs: drop disabled and unhandled pins from the status word
	always_comb begin
		pin_status = nxt.node_status & status_mask(pin_enable);
		phase      = nxt.phase;
	end

endmodule

`default_nettype wire

@@ hdl/group_debounce_edge_detector_core.sv @@
// Top level of the group debounce edge detector: registers, handshake, config.
// Depends on gde_pkg and gde_sweep.
//
// Usage:
//   Input stream (s_*): one word per sweep. s_tuser is the action
//   (0 sweep, 1 rebaseline); s_tdata holds pin_levels and now_tick.
//   Output stream (m_*): one word per input word with the per-pin status
//   (3 bits per pin: low, high, falling, rising, unknown) and the phase
//   after the sweep (check, debounce wait, update).
//   Config port: cfg_wr_en with cfg_index 0 writes debounce_ticks, index 1
//   writes pin_enable (low 8 bits). Write only while the block is idle.
// Timing:
//   A word accepted sits in the input register; its result is
//   registered in the output register (m_tvalid, m_tdata) when the output is free.
//   The sweep logic (one 32-bit subtract/compare and per-pin bit compares)
//   between the two registers sustains one word per cycle while the output
//   is not stalled; the state update for word k is in place before word
//   k+1 sweeps.
// Reset:
//   arst_n clears both valid bits, the stored levels, the pin statuses
//   (low), the timer origin and the phase (check); debounce_ticks resets
//   to 0 and pin_enable to all ones.
// Stall:
//   While m_tready is low a pending result holds; an empty input register still
//   takes one more word, then s_tready drops until the output drains.
`default_nettype none

module group_debounce_edge_detector_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [gde_pkg::IN_TDATA_W-1:0]      s_tdata,  // [7:0] pin_levels, [39:8] now_tick
	input  wire logic                                s_tuser,  // [0] action
	// Output stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [gde_pkg::OUT_TDATA_W-1:0]          m_tdata,  // [23:0] pin_status, [25:24] phase
	// Config write port
	input  wire logic                                cfg_wr_en,
	input  wire logic                                cfg_index,
	input  wire logic [gde_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import gde_pkg::*;

	// Config registers
	logic [TICK_W-1:0] debounce_ticks_q;
	logic [PIN_W-1:0]  pin_enable_q;

	// Input register
	logic              v_s1;
	logic              action_s1;
	logic [PIN_W-1:0]  levels_s1;
	logic [TICK_W-1:0] now_s1;

	// Block state
	gde_state_t state_q;
	gde_state_t state_nxt;

	logic [STATUS_W-1:0] pin_status;
	phase_t              phase;
	logic                adv;

	// Output register moves when it is empty or being taken
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= '0;
			pin_enable_q     <= {PIN_W{1'b1}};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_wdata[TICK_W-1:0];
				REG_PIN_ENABLE:     pin_enable_q     <= cfg_wdata[PIN_W-1:0];
				default:            ;
			endcase
		end
	end

	// Capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			levels_s1 <= s_tdata[PIN_W-1:0];
			now_s1    <= s_tdata[PIN_W +: TICK_W];
		end
	end

	gde_sweep u_sweep (
		.action         (action_s1),
		.pin_levels     (levels_s1),
		.now_tick       (now_s1),
		.debounce_ticks (debounce_ticks_q),
		.pin_enable     (pin_enable_q),
		.cur            (state_q),
		.nxt            (state_nxt),
		.pin_status     (pin_status),
		.phase          (phase)
	);

	// Commit state and result together, once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_levels <= '0;
			state_q.node_status <= '0;
			state_q.phase       <= PH_CHECK;
			state_q.start_tick  <= '0;
			m_tvalid            <= 1'b0;
		end else if (adv) begin
			m_tvalid <= v_s1;
			if (v_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			m_tdata <= {{(OUT_TDATA_W - STATUS_W - PHASE_W){1'b0}}, phase, pin_status};
		end
	end

	// A rebaseline word always leaves the block in check phase
	a_rebase_check: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && action_s1) |=> (state_q.phase == PH_CHECK))
		else $error("rebaseline did not return to check phase");

	// An update sweep returns to check and restarts the timer at its tick
	a_update_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && !action_s1 && state_q.phase == PH_UPDATE)
		|=> (state_q.phase == PH_CHECK && state_q.start_tick == $past(now_s1)))
		else $error("update sweep did not restart the timer");

	// Disabled pins never report a status
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[STATUS_W-1:0] & ~status_mask(pin_enable_q)) == '0))
		else $error("disabled pin reports nonzero status");

	// An empty output register never blocks the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// A stalled result is matched by a stall of the state
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(state_q))
		else $error("state moved while the result was stalled");

endmodule

`default_nettype wire
